// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int STATUS_W        = 2;
	localparam int OCC_W           = 5;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// storage port controls from the sequencer
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic idle;
		logic fin;
	} seq_stat_t;

endpackage

// ----- design/spq_in_if.sv -----
`timescale 1ns / 1ps

interface spq_in_if
	import spq_pkg::*;
	#(parameter int VALUE_WIDTH = VALUE_WIDTH_DEF)
	();

	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);

endinterface

// ----- design/spq_out_if.sv -----
`timescale 1ns / 1ps

interface spq_out_if
	import spq_pkg::*;
	#(parameter int VALUE_WIDTH = VALUE_WIDTH_DEF)
	();

	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] removed_value;
	logic [STATUS_W-1:0]           status;
	logic [OCC_W-1:0]              occupancy;

	modport source (output valid, output removed_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input removed_value, input status, input occupancy,
		output ready);

endinterface

// ----- design/spq_mem.sv -----
`timescale 1ns / 1ps

module spq_mem
	import spq_pkg::*;
	#(
		parameter int DEPTH       = DEPTH_DEF,
		parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
		localparam int AW         = $clog2(DEPTH)
	)
	(
		input  logic                          clk,
		input  mem_ctl_t                      ctl,
		input  logic [AW-1:0]                 wr_addr,
		input  logic signed [VALUE_WIDTH-1:0] wr_data,
		input  logic [AW-1:0]                 rd_addr,
		output logic signed [VALUE_WIDTH-1:0] rd_data_q
	);

	logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// ----- design/spq_seq.sv -----
`timescale 1ns / 1ps

module spq_seq
	import spq_pkg::*;
	#(
		parameter int DEPTH       = DEPTH_DEF,
		parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
		localparam int AW         = $clog2(DEPTH),
		localparam int CW         = $clog2(DEPTH + 1)
	)
	(
		input  logic                          clk,
		input  logic                          arst_n,
		input  logic                          start,
		input  logic                          start_op,
		input  logic signed [VALUE_WIDTH-1:0] start_value,
		input  logic                          fin_ready,
		output seq_stat_t                     stat,
		output logic signed [VALUE_WIDTH-1:0] removed_value,
		output status_t                       status,
		output logic [CW-1:0]                 count,
		output mem_ctl_t                      mem_ctl,
		output logic [AW-1:0]                 wr_addr,
		output logic signed [VALUE_WIDTH-1:0] wr_data,
		output logic [AW-1:0]                 rd_addr,
		input  logic signed [VALUE_WIDTH-1:0] rd_data
	);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_CMP  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [AW-1:0]                 head_q;
	logic [AW-1:0]                 tail_q;
	logic [CW-1:0]                 count_q;
	logic [AW-1:0]                 ptr_q;
	logic [CW-1:0]                 left_q;
	logic                          op_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic signed [VALUE_WIDTH-1:0] removed_q;
	status_t                       status_q;

	logic [AW-1:0] ptr_dec;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] tail_inc;
	logic          gt;

	// circular pointer steps and the shared compare
	assign ptr_dec  = (ptr_q == '0) ? LAST : ptr_q - AW'(1);
	assign head_inc = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + AW'(1);
	assign gt       = rd_data > val_q;

	always_comb begin
		mem_ctl = '0;
		rd_addr = (op_q == OP_REMOVE) ? head_q : ptr_dec;
		wr_addr = ptr_q;
		wr_data = val_q;
		unique case (state_q)
			S_RD: begin
				if (op_q == OP_INSERT && left_q == '0) begin
					mem_ctl.wr_en = 1'b1;
				end else begin
					mem_ctl.rd_en = 1'b1;
				end
			end
			S_CMP: begin
				if (op_q == OP_INSERT) begin
					mem_ctl.wr_en = 1'b1;
					if (gt) begin
						wr_data = rd_data;
					end
				end
			end
			S_IDLE, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
			left_q   <= '0;
			op_q     <= OP_INSERT;
			status_q <= ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= start_op;
						ptr_q    <= tail_q;
						left_q   <= count_q;
						status_q <= ST_DONE;
						if (start_op == OP_INSERT && count_q == FULL) begin
							status_q <= ST_FULL;
							state_q  <= S_FIN;
						end else if (start_op == OP_REMOVE && count_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (op_q == OP_INSERT && left_q == '0) begin
						tail_q  <= tail_inc;
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (op_q == OP_REMOVE) begin
						head_q  <= head_inc;
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end else if (gt) begin
						ptr_q   <= ptr_dec;
						left_q  <= left_q - CW'(1);
						state_q <= S_RD;
					end else begin
						tail_q  <= tail_inc;
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			val_q     <= start_value;
			removed_q <= '0;
		end else if (state_q == S_CMP && op_q == OP_REMOVE) begin
			removed_q <= rd_data;
		end
	end

	assign stat.idle     = (state_q == S_IDLE);
	assign stat.fin      = (state_q == S_FIN);
	assign removed_value = removed_q;
	assign status        = status_q;
	assign count         = count_q;

endmodule

// ----- design/sorted_priority_queue.sv -----
`timescale 1ns / 1ps

// Sorted priority queue: holds up to DEPTH signed values in ascending order in a
// circular buffer. An insert request walks back from the tail, moving each stored
// value that is strictly greater up by one slot, and drops the new value into the
// hole, so equal values leave in arrival order. A remove request returns the
// front value. Every request yields one response with status done, full (insert
// refused, queue unchanged) or empty (remove refused, removed_value zero) and
// the occupancy after the request. One request is worked at a time and req.ready
// is low meanwhile. The insert walk is paced by the single storage read port,
// whose registered read feeds the one compare unit: each slot is read, then
// compared and, if greater, written one slot up. A finished response waits in
// an output register, so the next request is taken while the response is still
// pending.

module sorted_priority_queue
	import spq_pkg::*;
	#(
		parameter int DEPTH       = DEPTH_DEF,
		parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
		localparam int AW         = $clog2(DEPTH),
		localparam int CW         = $clog2(DEPTH + 1)
	)
	(
		input logic clk,
		input logic arst_n,
		spq_in_if.sink  req,
		spq_out_if.source res
	);

	// sequencer hookup
	seq_stat_t                     stat;
	logic                          req_acc;
	logic                          fin_ready;
	logic signed [VALUE_WIDTH-1:0] fin_removed;
	status_t                       fin_status;
	logic [CW-1:0]                 fin_count;

	// storage hookup
	mem_ctl_t                      mem_ctl;
	logic [AW-1:0]                 wr_addr;
	logic signed [VALUE_WIDTH-1:0] wr_data;
	logic [AW-1:0]                 rd_addr;
	logic signed [VALUE_WIDTH-1:0] rd_data;

	// response register
	logic                          res_valid_q;
	logic signed [VALUE_WIDTH-1:0] res_removed_q;
	logic [STATUS_W-1:0]           res_status_q;
	logic [OCC_W-1:0]              res_occ_q;

	// a request is taken whenever the sequencer is idle
	assign req.ready = stat.idle;
	assign req_acc   = req.valid && req.ready;

	// the response register frees up in the same cycle it is taken
	assign fin_ready = !res_valid_q || res.ready;

	spq_seq #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (req_acc),
		.start_op      (req.operation),
		.start_value   (req.value),
		.fin_ready     (fin_ready),
		.stat          (stat),
		.removed_value (fin_removed),
		.status        (fin_status),
		.count         (fin_count),
		.mem_ctl       (mem_ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	spq_mem #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_mem (
		.clk       (clk),
		.ctl       (mem_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data)
	);

	// valid flag of the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (stat.fin && fin_ready) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// response payload, occupancy reported modulo the field width
	always_ff @(posedge clk) begin
		if (stat.fin && fin_ready) begin
			res_removed_q <= fin_removed;
			res_status_q  <= fin_status;
			res_occ_q     <= OCC_W'(fin_count);
		end
	end

	assign res.valid         = res_valid_q;
	assign res.removed_value = res_removed_q;
	assign res.status        = res_status_q;
	assign res.occupancy     = res_occ_q;

endmodule

// ----- design/spq_chk.sv -----
`timescale 1ns / 1ps

module spq_chk
	import spq_pkg::*;
	#(
		parameter int DEPTH       = DEPTH_DEF,
		parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
	)
	(
		input logic                   clk,
		input logic                   arst_n,
		input logic                   in_valid,
		input logic                   in_ready,
		input logic                   out_valid,
		input logic                   out_ready,
		input logic [VALUE_WIDTH-1:0] out_removed,
		input logic [STATUS_W-1:0]    out_status,
		input logic [OCC_W-1:0]       out_occ
	);

	// held response keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_removed)
			&& $stable(out_status) && $stable(out_occ))
		else $error("response changed while stalled");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a full refusal only happens at full occupancy
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_FULL |-> out_occ == OCC_W'(DEPTH))
		else $error("full status with queue not full");

	// an empty refusal only happens with nothing stored
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_EMPTY |-> out_occ == '0)
		else $error("empty status with values stored");

	// refused requests return no value
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_DONE |-> out_removed == '0)
		else $error("refused request returned a value");

endmodule

bind sorted_priority_queue spq_chk #(
	.DEPTH       (DEPTH),
	.VALUE_WIDTH (VALUE_WIDTH)
) u_spq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.out_removed (res.removed_value),
	.out_status  (res.status),
	.out_occ     (res.occupancy)
);
